[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on a rising edge with an
// active-low reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

[hdl/swse_pkg.sv]
// ----------------------------------------------------------------------------
// swse_pkg
// Widths, defaults, sizing helpers and the command bundle shared by the
// slope estimator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swse_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SLOPE_W    = 24;
  localparam int unsigned WINDOW_DEF = 16;
  // Fraction bits of the result; the dividend carries one more for rounding.
  localparam int unsigned Q_FRAC     = 8;

  // Signed width of a position weight N*x - sum(x), whose magnitude is below N*N/2.
  function automatic int unsigned coef_w(input int unsigned n);
    return $clog2(n * n) + 1;
  endfunction

  // Signed width of the weighted sum; the sum of weight magnitudes is below N^3.
  function automatic int unsigned acc_w(input int unsigned n);
    return $clog2(n * n * n) + SAMPLE_W + 1;
  endfunction

  // Width of the rounded dividend |num| * 2^(Q_FRAC+1) + divisor.
  function automatic int unsigned dv_w(input int unsigned n);
    return acc_w(n) + Q_FRAC + 2;
  endfunction

  // Number of trailing zero bits of a nonzero constant.
  function automatic int unsigned tz_cnt(input longint unsigned v);
    longint unsigned r;
    int unsigned     n;
    r = v;
    n = 0;
    while ((r != 0) && !r[0]) begin
      r = r >> 1;
      n++;
    end
    return n;
  endfunction

  // Sum of the positive position weights; the negative ones mirror them.
  function automatic longint unsigned pos_wsum(input int unsigned n);
    longint          nn;
    longint          w;
    longint unsigned s;
    nn = longint'(n);
    s  = 0;
    for (int x = 0; x < n; x++) begin
      w = nn * x - nn * (nn - 1) / 2;
      if (w > 0) begin
        s = s + 64'(w);
      end
    end
    return s;
  endfunction

  typedef struct packed {
    logic shift_in;   // take a new sample into the window
    logic mac_issue;  // one multiply step, window rotates by one
    logic div_load;   // scale and clamp the finished sum
    logic div_step;   // reciprocal multiply
    logic out_load;   // capture the saturated quotient as the result
  } cmd_t;

endpackage

`default_nettype wire

[hdl/swse_ctrl.sv]
// ----------------------------------------------------------------------------
// swse_ctrl
// Sequencer for the slope estimator: accepts a sample, steps the multiply
// pass over the window, then the divider, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module swse_ctrl #(
  parameter int unsigned WINDOW = swse_pkg::WINDOW_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  wire logic         m_ready_i,
  output swse_pkg::cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               m_valid_q, m_valid_d;
  logic               accept;
  logic               out_free;

  assign accept   = s_valid_i && (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.shift_in  = accept;
    cmd_o.mac_issue = (state_q == ST_MAC);
    cmd_o.div_load  = (state_q == ST_LOAD);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.out_load  = (state_q == ST_FIN) && out_free;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WINDOW - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      // The last product is added to the sum during this cycle.
      ST_DRAIN: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

`default_nettype wire

[hdl/swse_dpath.sv]
// ----------------------------------------------------------------------------
// swse_dpath
// Window shift line, weighted multiply-accumulate, division by the fixed
// least-squares divisor through a reciprocal multiply, and saturation into
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swse_dpath #(
  parameter int unsigned WINDOW = swse_pkg::WINDOW_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire swse_pkg::cmd_t                 cmd_i,
  input  wire logic [swse_pkg::SAMPLE_W-1:0]  sample_i,
  output logic      [swse_pkg::SLOPE_W-1:0]   slope_o
);

  localparam int unsigned SW      = swse_pkg::SAMPLE_W;
  localparam int unsigned OW      = swse_pkg::SLOPE_W;
  localparam int unsigned CW      = swse_pkg::coef_w(WINDOW);
  localparam int unsigned AW      = swse_pkg::acc_w(WINDOW);
  localparam int unsigned DVW     = swse_pkg::dv_w(WINDOW);
  localparam int unsigned PW      = CW + SW + 1;
  localparam int unsigned SUM_X   = WINDOW * (WINDOW - 1) / 2;
  localparam int unsigned DIVISOR = WINDOW * WINDOW * (WINDOW * WINDOW - 1) / 12;
  localparam int unsigned SHIFT   = swse_pkg::Q_FRAC + 1;
  localparam longint unsigned TWO_D   = 64'(DIVISOR) * 2;
  localparam int unsigned     TZ      = swse_pkg::tz_cnt(TWO_D);
  localparam longint unsigned ODD     = TWO_D >> TZ;
  localparam longint unsigned DVD_MAX = swse_pkg::pos_wsum(WINDOW) * ((64'd1 << SW) - 1) *
                                        (64'd1 << SHIFT) + 64'(DIVISOR);
  localparam longint unsigned X_SAT   = ((64'd1 << (OW - 1)) + 1) * ODD;
  localparam longint unsigned X_MAX   = ((DVD_MAX >> TZ) < X_SAT) ? (DVD_MAX >> TZ) : X_SAT;
  localparam int unsigned     XW      = $clog2(X_MAX + 1);
  localparam int unsigned     K       = XW + $clog2(ODD);
  localparam longint unsigned M_REC   = ((64'd1 << K) / ODD) + 1;
  localparam int unsigned     MW      = $clog2(M_REC + 1);
  localparam int unsigned     PRW     = XW + MW;
  localparam int unsigned     QEW     = (PRW - K > OW) ? PRW - K : OW + 1;
  localparam logic [DVW-1:0] X_MAX_V   = DVW'(X_MAX);
  localparam logic [MW-1:0]  M_REC_V   = MW'(M_REC);
  localparam logic [QEW-1:0] Q_POS_MAX = QEW'((64'd1 << (OW - 1)) - 1);
  localparam logic [QEW-1:0] Q_NEG_MAX = QEW'(64'd1 << (OW - 1));

  logic [SW-1:0]           win_q [WINDOW];
  logic [SW-1:0]           win_in;
  logic signed [CW-1:0]    coef_q;
  logic signed [PW-1:0]    prod_q;
  logic                    pv_q;
  logic signed [AW-1:0]    acc_q;
  logic [AW-1:0]           mag;
  logic [DVW-1:0]          dvd;
  logic [DVW-1:0]          dsh;
  logic [XW-1:0]           x_d;
  logic [XW-1:0]           x_q;
  logic [PRW-1:0]          qp_q;
  logic [QEW-1:0]          qx;
  logic                    neg_q;
  logic [OW-1:0]           q_lo;
  logic [OW-1:0]           sat;
  logic [OW-1:0]           out_q;

  // Oldest sample sits at index 0. During the multiply pass the line rotates,
  // so index 0 presents each position in turn and the window ends up unchanged.
  assign win_in = cmd_i.shift_in ? sample_i : win_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) begin
        win_q[k] <= '0;
      end
      pv_q <= 1'b0;
    end else begin
      if (cmd_i.shift_in || cmd_i.mac_issue) begin
        for (int k = 0; k < WINDOW - 1; k++) begin
          win_q[k] <= win_q[k + 1];
        end
        win_q[WINDOW - 1] <= win_in;
      end
      pv_q <= cmd_i.mac_issue;
    end
  end

  // Weight for position x is N*x - sum(x), stepped by N per position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in) begin
      coef_q <= -$signed(CW'(SUM_X));
      acc_q  <= '0;
    end else begin
      if (cmd_i.mac_issue) begin
        coef_q <= coef_q + $signed(CW'(WINDOW));
        prod_q <= coef_q * $signed({1'b0, win_q[0]});
      end
      if (pv_q) begin
        acc_q <= acc_q + AW'(prod_q);
      end
    end
  end

  // Round half away from zero: (|num| * 512 + D) / (2 * D).
  assign mag = acc_q[AW-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
  assign dvd = DVW'({mag, SHIFT'(0)}) + DVW'(DIVISOR);

  // The power-of-two part of 2*D is a shift and the odd part a multiply by a
  // rounded-up reciprocal, exact over the clamped range. A dividend above the
  // clamp gives a quotient that saturates in either sign anyway.
  assign dsh = dvd >> TZ;
  assign x_d = (dsh > X_MAX_V) ? XW'(X_MAX) : dsh[XW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      x_q   <= x_d;
      neg_q <= acc_q[AW-1];
    end
    if (cmd_i.div_step) begin
      qp_q <= x_q * M_REC_V;
    end
  end

  assign qx   = QEW'(qp_q >> K);
  assign q_lo = qx[OW-1:0];

  always_comb begin
    if (!neg_q) begin
      sat = (qx > Q_POS_MAX) ? {1'b0, {(OW-1){1'b1}}} : q_lo;
    end else begin
      sat = (qx > Q_NEG_MAX) ? {1'b1, {(OW-1){1'b0}}} : -q_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= sat;
    end
  end

  assign slope_o = out_q;

endmodule

`default_nettype wire

[hdl/sliding_window_slope_estimator_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_slope_estimator_unit
// Least-squares slope over the last WINDOW samples, Q.8 signed, rounded.
//
//   Channel   Dir  Data bits               Meaning
//   s_axis    in   tdata[15:0]  sample     unsigned sample, hundredths of ppm
//   m_axis    out  tdata[23:0]  slope      signed slope per sample, Q.8
//
// Each beat runs from acceptance to a loaded result in these steps: one multiply
// per window entry, adding the last product, scaling and clamping the sum, a
// reciprocal multiply for the division and saturation into the result register.
// The next beat is taken once the sequencer is back in idle, so a new sample is
// not accepted while the previous one is still being computed.
// Reset clears the window to zeros; early results treat them as samples.
// A waiting result does not block the next input beat; a finished
// computation waits only while the result register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_slope_estimator_unit #(
  parameter int unsigned WINDOW = swse_pkg::WINDOW_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [swse_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [swse_pkg::SLOPE_W-1:0]  m_axis_tdata    // [23:0] slope
);

  swse_pkg::cmd_t cmd;

  swse_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  swse_dpath #(
    .WINDOW (WINDOW)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (s_axis_tdata),
    .slope_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[hdl/swse_checker.sv]
// ----------------------------------------------------------------------------
// swse_checker
// Port-level checks for the slope estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swse_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [swse_pkg::SLOPE_W-1:0]  m_axis_tdata
);

  logic s_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;

  // An accepted sample keeps the block busy for at least the next cycle.
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, s_beat |=> !s_axis_tready, "ready after accept")

  // A new result only appears at the end of a computation.
  `ASSERT_PROP(a_result_from_work, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without work")

  // A stalled result beat holds its data.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind sliding_window_slope_estimator_unit swse_checker u_swse_checker (.*);

`default_nettype wire

[test/tb_sliding_window_slope_estimator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_slope_estimator_unit
// Streams concentration samples into the slope estimator and checks every
// slope beat against a behavioral window-and-fit predictor kept in the bench.
// A directed start covers the zero-filled window after reset, full-scale
// swings and single-bit samples. Random ramps, steps, flat levels, jitter and
// noise follow, under random gaps on both streams, with a back-to-back
// stretch and a full drain in the middle.
// ----------------------------------------------------------------------------

module tb_sliding_window_slope_estimator_unit;

  localparam int unsigned SAMPLE_W      = swse_pkg::SAMPLE_W;
  localparam int unsigned SLOPE_W       = swse_pkg::SLOPE_W;
  localparam int unsigned Q_FRAC        = swse_pkg::Q_FRAC;
  localparam int unsigned WIN           = 16;
  localparam longint      POS_SUM       = longint'(WIN) * (WIN - 1) / 2;
  localparam longint      FIT_DIV       = longint'(WIN) * WIN * (longint'(WIN) * WIN - 1) / 12;
  localparam longint      SLOPE_HI      = (longint'(1) << (SLOPE_W - 1)) - 1;
  localparam longint      SLOPE_LO      = -(longint'(1) << (SLOPE_W - 1));
  localparam int          SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam int unsigned SETTLE_CYCLES = 4 * (WIN + 48);
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum int unsigned {
    PROFILE_FLAT,
    PROFILE_RAMP,
    PROFILE_STEP,
    PROFILE_JITTER,
    PROFILE_NOISE
  } profile_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata  = '0;   // [15:0] sample
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SLOPE_W-1:0]  m_axis_tdata;         // [23:0] slope

  // Bench copy of the sample window, oldest entry at index 0.
  logic [SAMPLE_W-1:0] hist [WIN];
  logic [SLOPE_W-1:0]  slope_q [$];

  bit          idle_on        = 1'b1;
  int unsigned sink_hold      = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned fail_count     = 0;
  int unsigned samples_sent   = 0;
  int unsigned slopes_checked = 0;

  sliding_window_slope_estimator_unit #(
    .WINDOW(WIN)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    for (int k = 0; k < WIN; k++) hist[k] = '0;
  end

  // Shifts one sample into the window and returns the rounded Q.8 fit slope.
  function automatic logic [SLOPE_W-1:0] shift_and_fit(input logic [SAMPLE_W-1:0] sample);
    longint weighted;
    longint mag;
    longint quo;
    for (int k = 0; k < WIN - 1; k++) hist[k] = hist[k + 1];
    hist[WIN - 1] = sample;
    weighted = 0;
    for (int x = 0; x < WIN; x++) begin
      weighted += (longint'(WIN) * x - POS_SUM) * longint'(hist[x]);
    end
    mag = (weighted < 0) ? -weighted : weighted;
    // Halfway cases round away from zero because the magnitude is rounded.
    quo = (mag * (longint'(1) << (Q_FRAC + 1)) + FIT_DIV) / (2 * FIT_DIV);
    if (weighted < 0) quo = -quo;
    if (quo > SLOPE_HI) quo = SLOPE_HI;
    if (quo < SLOPE_LO) quo = SLOPE_LO;
    return quo[SLOPE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int value);
    if (value < 0) return '0;
    if (value > SAMPLE_MAX) return SAMPLE_MAX[SAMPLE_W-1:0];
    return value[SAMPLE_W-1:0];
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    slope_q.push_back(shift_and_fit(value));
    samples_sent++;
  endtask

  task automatic source_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (slope_q.size() != 0) @(posedge clk_i);
  endtask

  // Zero window, then alternating bit patterns while most entries are still zero.
  task automatic test_startup_patterns();
    push_sample(16'h0000);
    push_sample(16'hAAAA);
    push_sample(16'h5555);
  endtask

  // Full scale in the newer half gives the steepest rise, then in the older
  // half the steepest fall.
  task automatic test_full_scale_swing();
    repeat (WIN / 2) push_sample(SAMPLE_MAX[SAMPLE_W-1:0]);
    repeat (WIN / 2) push_sample(16'h0000);
  endtask

  task automatic test_single_lsb();
    push_sample(16'h0001);
    push_sample(16'h8000);
  endtask

  task automatic test_profile_sequences(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    profile_e    kind;
    int          level;
    int          level2;
    int          step;
    int          value;
    sent = 0;
    while (sent < count) begin
      kind = profile_e'($urandom_range(0, 4));
      len  = $urandom_range(4, 3 * WIN);
      case ($urandom_range(0, 3))
        0: level = 0;
        1: level = SAMPLE_MAX;
        default: level = $urandom_range(0, SAMPLE_MAX);
      endcase
      level2 = $urandom_range(0, SAMPLE_MAX);
      if ($urandom_range(0, 1) == 0) begin
        step = int'($urandom_range(0, 512)) - 256;
      end else begin
        step = int'($urandom_range(0, 16384)) - 8192;
      end
      for (int i = 0; i < len; i++) begin
        case (kind)
          PROFILE_FLAT:   value = level;
          PROFILE_RAMP:   value = level + step * i;
          PROFILE_STEP:   value = (i < len / 2) ? level : level2;
          PROFILE_JITTER: value = level + int'($urandom_range(0, 512)) - 256;
          default:        value = $urandom_range(0, SAMPLE_MAX);
        endcase
        push_sample(clamp_sample(value));
      end
      sent += len;
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    idle_on = 1'b0;
    repeat (count) push_sample(16'($urandom));
    idle_on = 1'b1;
  endtask

  // The source stops until every pending slope has been delivered.
  task automatic test_drain_pause();
    repeat (20) push_sample(16'($urandom));
    source_idle();
    wait_for_drain();
    repeat (20) push_sample(16'($urandom));
  endtask

  task automatic test_white_noise(input int unsigned count);
    repeat (count) push_sample(16'($urandom));
  endtask

  // Result sink: checks each accepted beat and draws its own stall per beat.
  always @(posedge clk_i) begin : slope_sink
    int unsigned         stall;
    logic [SLOPE_W-1:0]  want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (slope_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: slope beat %0d arrived with no sample pending",
                     $time, $signed(m_axis_tdata));
          end
        end else begin
          want = slope_q.pop_front();
          if (m_axis_tdata !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: slope mismatch on result %0d: expected %0d, got %0d",
                       $time, slopes_checked, $signed(want), $signed(m_axis_tdata));
            end
          end
          slopes_checked++;
        end
        stall = idle_on ? $urandom_range(0, 5) : 0;
        sink_hold     <= stall;
        m_axis_tready <= (stall == 0);
      end else if (sink_hold != 0) begin
        sink_hold     <= sink_hold - 1;
        m_axis_tready <= (sink_hold == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("sliding_window_slope_estimator_unit regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_startup_patterns();
    test_full_scale_swing();
    test_single_lsb();
    test_profile_sequences(700);
    test_back_to_back(150);
    test_drain_pause();
    test_white_noise(200);
    source_idle();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples and checked %0d slopes: reset fill, full-scale swings,",
             samples_sent, slopes_checked);
    $display("ramp, step, flat, jitter and noise runs with random and no stalls, one drain.");
    if (fail_count == 0) begin
      $display("sliding_window_slope_estimator_unit regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("sliding_window_slope_estimator_unit regression: fail");
    end
    $finish;
  end

endmodule

[sliding_window_slope_estimator_unit.f]
+incdir+hdl
hdl/swse_pkg.sv
hdl/swse_ctrl.sv
hdl/swse_dpath.sv
hdl/sliding_window_slope_estimator_unit.sv
hdl/swse_checker.sv
test/tb_sliding_window_slope_estimator_unit.sv
